// ----- rtl/core/arpc_pkg.sv -----
// shared widths, codes and constants of the arp cache and responder
package arpc_pkg;

  localparam int unsigned CACHE_ENTRIES = 16;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned OpcW    = 16;
  localparam int unsigned IpW     = 32;
  localparam int unsigned MacW    = 48;
  localparam int unsigned StatusW = 3;
  localparam int unsigned TxOpW   = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 48;

  localparam logic [CmdW-1:0] CMD_LOOKUP  = 2'd0;
  localparam logic [CmdW-1:0] CMD_RECEIVE = 2'd1;
  localparam logic [CmdW-1:0] CMD_SEND    = 2'd2;

  localparam logic [OpcW-1:0] OPC_REQUEST = 16'd1;
  localparam logic [OpcW-1:0] OPC_REPLY   = 16'd2;

  localparam logic [TxOpW-1:0] TXOP_NONE    = 2'd0;
  localparam logic [TxOpW-1:0] TXOP_REQUEST = 2'd1;
  localparam logic [TxOpW-1:0] TXOP_REPLY   = 2'd2;

  localparam logic [StatusW-1:0] ST_HIT     = 3'd0;
  localparam logic [StatusW-1:0] ST_MISS    = 3'd1;
  localparam logic [StatusW-1:0] ST_TX      = 3'd2;
  localparam logic [StatusW-1:0] ST_LEARNED = 3'd3;
  localparam logic [StatusW-1:0] ST_BADOP   = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_OWN_IP  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_OWN_MAC = 1'd1;

  localparam logic [IpW-1:0]  BCAST_IP  = 32'hFFFF_FFFF;
  localparam logic [MacW-1:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

endpackage

// ----- rtl/core/arpc_if.sv -----
// handshake channels of the arp cache and responder
interface arpc_req_if;
  logic                          valid;
  logic                          ready;
  logic [arpc_pkg::CmdW-1:0]     command;
  logic [arpc_pkg::OpcW-1:0]     arp_opcode;
  logic [arpc_pkg::IpW-1:0]      sender_ip;
  logic [arpc_pkg::MacW-1:0]     sender_mac;
  logic [arpc_pkg::IpW-1:0]      tgt_ip;

  modport source (output valid, command, arp_opcode, sender_ip, sender_mac, tgt_ip,
                  input ready);
  modport sink (input valid, command, arp_opcode, sender_ip, sender_mac, tgt_ip,
                output ready);
endinterface

interface arpc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [arpc_pkg::StatusW-1:0]  status;
  logic [arpc_pkg::MacW-1:0]     found_mac;
  logic [arpc_pkg::MacW-1:0]     tx_dest_mac;
  logic [arpc_pkg::TxOpW-1:0]    tx_opcode;
  logic [arpc_pkg::IpW-1:0]      tx_tgt_ip;
  logic [arpc_pkg::MacW-1:0]     tx_target_mac;

  modport source (output valid, status, found_mac, tx_dest_mac, tx_opcode, tx_tgt_ip,
                  tx_target_mac, input ready);
  modport sink (input valid, status, found_mac, tx_dest_mac, tx_opcode, tx_tgt_ip,
                tx_target_mac, output ready);
endinterface

interface arpc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [arpc_pkg::CfgIdxW-1:0]  index;
  logic [arpc_pkg::CfgW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/arp_cache_and_responder_core.sv -----
// arp cache and responder: ip-to-mac table, lookup, learning and frame field generation
//
// req_i takes one command transaction at a time: lookup, received arp packet or
// send request. every command gives exactly one transaction on rsp_o.
// cfg_i writes own_ip (index 0) and own_mac (index 1); it is always ready. the user must
// write it only while no command is in flight; the block itself does not enforce this.
// the table sits in two single-port arrays with a registered read; one shared
// comparator walks the filled entries, one entry per cycle, with the read of the
// next entry overlapping the compare of the current one.
// lookup and learning walk up to fill entries (fill = entries in use, at most
// CacheEntries); send-request, unknown opcodes and reserved commands skip the walk.
// req_i is not ready while a command is being worked on.
// the result register lets a new command be accepted while a result still
// waits; a finished command holds, table untouched, until rsp_o frees up.
// reset empties the table (fill count to zero), clears own_ip and own_mac and
// drops any waiting result.
module arp_cache_and_responder_core #(
  parameter int unsigned CacheEntries = arpc_pkg::CACHE_ENTRIES
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  arpc_req_if.sink        req_i,
  arpc_rsp_if.source      rsp_o,
  arpc_cfg_if.sink        cfg_i
);

  localparam int unsigned CntW = $clog2(CacheEntries + 1);
  localparam int unsigned IdxW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;

  localparam logic StIdle = 1'b0;
  localparam logic StBusy = 1'b1;

  logic                           state_q, state_d;
  logic [CntW-1:0]                fill_q, fill_d;
  logic [CntW-1:0]                rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]                cmp_idx_q;
  logic                           pend_q, pend_d;
  logic                           scan_q;

  logic [arpc_pkg::CmdW-1:0]      cmd_q;
  logic [arpc_pkg::OpcW-1:0]      opc_q;
  logic [arpc_pkg::IpW-1:0]       sip_q;
  logic [arpc_pkg::MacW-1:0]      smac_q;
  logic [arpc_pkg::IpW-1:0]       tip_q;
  logic [arpc_pkg::IpW-1:0]       key_q;

  logic [arpc_pkg::IpW-1:0]       own_ip_q;
  logic [arpc_pkg::MacW-1:0]      own_mac_q;

  logic [arpc_pkg::IpW-1:0]       ip_mem [CacheEntries];
  logic [arpc_pkg::MacW-1:0]      mac_mem [CacheEntries];
  logic [arpc_pkg::IpW-1:0]       rd_ip_q;
  logic [arpc_pkg::MacW-1:0]      rd_mac_q;

  logic                           out_vld_q;
  logic [arpc_pkg::StatusW-1:0]   status_q, status_d;
  logic [arpc_pkg::MacW-1:0]      found_mac_q, found_mac_d;
  logic [arpc_pkg::MacW-1:0]      dest_mac_q, dest_mac_d;
  logic [arpc_pkg::TxOpW-1:0]     tx_op_q, tx_op_d;
  logic [arpc_pkg::IpW-1:0]       tx_ip_q, tx_ip_d;
  logic [arpc_pkg::MacW-1:0]      tx_mac_q, tx_mac_d;

  logic                           req_acc;
  logic                           busy;
  logic                           issue;
  logic                           match;
  logic                           done;
  logic                           finish;
  logic                           rd_en;
  logic                           learn;
  logic                           has_room;
  logic                           we;
  logic [IdxW-1:0]                wr_addr;

  assign req_i.ready = (state_q == StIdle);
  assign req_acc     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign busy     = (state_q == StBusy);
  assign issue    = scan_q && (rd_idx_q < fill_q);
  assign match    = pend_q && (rd_ip_q == key_q);
  assign done     = !scan_q || match || (!pend_q && !issue);
  assign finish   = busy && done && (!out_vld_q || rsp_o.ready);
  assign rd_en    = busy && !done && issue;
  assign learn    = (cmd_q == arpc_pkg::CMD_RECEIVE)
                    && (opc_q inside {arpc_pkg::OPC_REQUEST, arpc_pkg::OPC_REPLY});
  assign has_room = (fill_q < CntW'(CacheEntries));
  assign we       = finish && learn && (match || has_room);
  assign wr_addr  = match ? cmp_idx_q : fill_q[IdxW-1:0];

  // sequencer
  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    pend_d   = pend_q;
    fill_d   = fill_q;
    if (req_acc) begin
      state_d  = StBusy;
      rd_idx_d = '0;
      pend_d   = 1'b0;
    end else if (finish) begin
      state_d = StIdle;
      if (learn && !match && has_room) begin
        fill_d = fill_q + CntW'(1);
      end
    end else if (busy && !done) begin
      pend_d = issue;
      if (issue) begin
        rd_idx_d = rd_idx_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fill_q    <= '0;
      rd_idx_q  <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
      own_ip_q  <= '0;
      own_mac_q <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      rd_idx_q <= rd_idx_d;
      pend_q   <= pend_d;
      if (finish) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          arpc_pkg::CFG_OWN_IP:  own_ip_q  <= cfg_i.data[arpc_pkg::IpW-1:0];
          arpc_pkg::CFG_OWN_MAC: own_mac_q <= cfg_i.data[arpc_pkg::MacW-1:0];
          default: ;
        endcase
      end
    end
  end

  // command fields
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      cmd_q  <= req_i.command;
      opc_q  <= req_i.arp_opcode;
      sip_q  <= req_i.sender_ip;
      smac_q <= req_i.sender_mac;
      tip_q  <= req_i.tgt_ip;
      key_q  <= (req_i.command == arpc_pkg::CMD_LOOKUP) ? req_i.tgt_ip : req_i.sender_ip;
      scan_q <= (req_i.command == arpc_pkg::CMD_LOOKUP)
                || ((req_i.command == arpc_pkg::CMD_RECEIVE)
                    && (req_i.arp_opcode inside {arpc_pkg::OPC_REQUEST,
                                                 arpc_pkg::OPC_REPLY}));
    end
    if (rd_en) begin
      cmp_idx_q <= rd_idx_q[IdxW-1:0];
    end
  end

  // table storage
  always_ff @(posedge clk_i) begin
    if (we) begin
      ip_mem[wr_addr]  <= sip_q;
      mac_mem[wr_addr] <= smac_q;
    end
    if (rd_en) begin
      rd_ip_q  <= ip_mem[rd_idx_q[IdxW-1:0]];
      rd_mac_q <= mac_mem[rd_idx_q[IdxW-1:0]];
    end
  end

  // result
  always_comb begin
    status_d    = arpc_pkg::ST_MISS;
    found_mac_d = '0;
    dest_mac_d  = '0;
    tx_op_d     = arpc_pkg::TXOP_NONE;
    tx_ip_d     = '0;
    tx_mac_d    = '0;
    case (cmd_q)
      arpc_pkg::CMD_LOOKUP: begin
        if (match) begin
          status_d    = arpc_pkg::ST_HIT;
          found_mac_d = rd_mac_q;
        end
      end
      arpc_pkg::CMD_RECEIVE: begin
        case (opc_q)
          arpc_pkg::OPC_REQUEST: begin
            if ((tip_q == own_ip_q) || (tip_q == arpc_pkg::BCAST_IP)) begin
              status_d   = arpc_pkg::ST_TX;
              dest_mac_d = smac_q;
              tx_op_d    = arpc_pkg::TXOP_REPLY;
              tx_ip_d    = sip_q;
              tx_mac_d   = smac_q;
            end else begin
              status_d = arpc_pkg::ST_LEARNED;
            end
          end
          arpc_pkg::OPC_REPLY: status_d = arpc_pkg::ST_LEARNED;
          default:             status_d = arpc_pkg::ST_BADOP;
        endcase
      end
      arpc_pkg::CMD_SEND: begin
        status_d   = arpc_pkg::ST_TX;
        dest_mac_d = arpc_pkg::BCAST_MAC;
        tx_op_d    = arpc_pkg::TXOP_REQUEST;
        tx_ip_d    = tip_q;
        tx_mac_d   = arpc_pkg::BCAST_MAC;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      status_q    <= status_d;
      found_mac_q <= found_mac_d;
      dest_mac_q  <= dest_mac_d;
      tx_op_q     <= tx_op_d;
      tx_ip_q     <= tx_ip_d;
      tx_mac_q    <= tx_mac_d;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.found_mac     = found_mac_q;
  assign rsp_o.tx_dest_mac   = dest_mac_q;
  assign rsp_o.tx_opcode     = tx_op_q;
  assign rsp_o.tx_tgt_ip     = tx_ip_q;
  assign rsp_o.tx_target_mac = tx_mac_q;

endmodule
